### src/pct_pkg.sv
// Shared types and constants for the policy countdown timer.
package pct_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int VALUE_W         = 32;
    localparam int SHOWN_W         = 32;
    localparam int POLICY_W        = 6;

    // Policy bit positions.
    localparam int POL_WRAP     = 0;
    localparam int POL_CONT     = 1;
    localparam int POL_NOTRIG   = 2;
    localparam int POL_NORELOAD = 3;
    localparam int POL_NOROUND  = 4;
    localparam int POL_ONDEC    = 5;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_SET_COUNT = 3'd1,
        KIND_SET_LIMIT = 3'd2,
        KIND_RUN       = 3'd3,
        KIND_STOP      = 3'd4,
        KIND_READ      = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_ONESHOT  = 2'd2
    } t_mode;

    // How a new schedule treats the owed extra period.
    typedef enum logic [1:0] {
        ADJ_ZERO = 2'd0,
        ADJ_ONE  = 2'd1,
        ADJ_SKIP = 2'd2
    } t_adj;

endpackage

### src/pct_core.sv
// Timer state registers and the combinational update for one command beat.
module pct_core import pct_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [POLICY_W-1:0]    i_cfg_wdata,
    input  logic                   i_step,
    input  logic [2:0]             i_kind,
    input  logic [COUNT_WIDTH-1:0] i_value,
    input  logic                   i_flag,
    output logic [COUNT_WIDTH-1:0] o_shown,
    output logic                   o_fired,
    output t_mode                  o_mode
);

    localparam logic [COUNT_WIDTH-1:0] CZERO = '0;
    localparam logic [COUNT_WIDTH-1:0] CONE  = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    logic [POLICY_W-1:0]    r_pol;
    logic [COUNT_WIDTH-1:0] r_ticks, n_ticks;
    logic [COUNT_WIDTH-1:0] r_reload, n_reload;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    t_mode                  r_mode, n_mode;
    logic                   r_adjm, n_adjm;
    logic                   r_fresh, n_fresh;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
        sat_inc = (&x) ? x : x + CONE;
    endfunction

    // Counter readout as seen at a tick instant.
    function automatic logic [COUNT_WIDTH-1:0] read_count(
        input t_mode                  mode,
        input logic [COUNT_WIDTH-1:0] cnt,
        input logic [COUNT_WIDTH-1:0] ticks,
        input logic                   adjm,
        input logic                   fresh,
        input logic [COUNT_WIDTH-1:0] rel,
        input logic [POLICY_W-1:0]    pol
    );
        logic [COUNT_WIDTH-1:0] c;
        logic                   zero_out;
        zero_out = 1'b0;
        if (ticks == CZERO && !adjm) begin
            c = CZERO;
        end else begin
            c = adjm ? sat_inc(ticks) : ticks;
            if (pol[POL_WRAP] && mode != MODE_ONESHOT && cnt == rel) begin
                if (fresh) begin
                    zero_out = adjm;
                end else begin
                    zero_out = (c == rel);
                end
            end
        end
        if (pol[POL_NOROUND] && !fresh) begin
            c = sat_inc(c);
        end
        if (mode == MODE_OFF || cnt == CZERO) begin
            read_count = cnt;
        end else if (zero_out) begin
            read_count = CZERO;
        end else begin
            read_count = c;
        end
    endfunction

    always_comb begin
        logic                   fire;
        logic                   rs_req;
        t_adj                   rs_adj;
        logic                   suppress;
        logic                   extra;
        logic                   none;
        logic [COUNT_WIDTH-1:0] tk_dec;
        n_ticks  = r_ticks;
        n_reload = r_reload;
        n_cnt    = r_cnt;
        n_mode   = r_mode;
        n_adjm   = r_adjm;
        n_fresh  = r_fresh;
        fire     = 1'b0;
        rs_req   = 1'b0;
        rs_adj   = ADJ_ZERO;
        none     = 1'b0;
        tk_dec   = (r_ticks != CZERO) ? r_ticks - CONE : r_ticks;

        // First half: the command itself, and the expiry on a tick.
        case (t_kind'(i_kind))
            KIND_TICK: begin
                if (r_mode != MODE_OFF) begin
                    n_fresh = 1'b0;
                    if (r_adjm) begin
                        n_adjm = 1'b0;
                    end else begin
                        n_ticks = tk_dec;
                    end
                    // The owed period is used up either way, so a zero count expires.
                    if (n_ticks == CZERO) begin
                        fire = 1'b1;
                        if (r_mode == MODE_ONESHOT) begin
                            n_cnt  = CZERO;
                            n_mode = MODE_OFF;
                        end else begin
                            rs_adj = (r_cnt == CZERO || r_reload == CZERO) ? ADJ_SKIP : ADJ_ONE;
                            if (!r_pol[POL_NOTRIG]) begin
                                fire = (rs_adj == ADJ_ONE);
                            end
                            n_cnt  = r_reload;
                            rs_req = 1'b1;
                        end
                    end
                end
            end
            KIND_SET_COUNT: begin
                n_cnt  = i_value;
                rs_req = (r_mode != MODE_OFF);
            end
            KIND_SET_LIMIT: begin
                n_reload = i_value;
                if (i_flag) begin
                    n_cnt  = i_value;
                    rs_req = (r_mode != MODE_OFF);
                end
            end
            KIND_RUN: begin
                n_mode = i_flag ? MODE_ONESHOT : MODE_PERIODIC;
                rs_req = (r_mode == MODE_OFF);
            end
            KIND_STOP: begin
                if (r_mode != MODE_OFF) begin
                    n_cnt  = read_count(r_mode, r_cnt, r_ticks, r_adjm, r_fresh,
                                        r_reload, r_pol);
                    n_mode = MODE_OFF;
                end
            end
            default: begin
            end
        endcase

        // Second half: start a new schedule when the command asks for one.
        suppress = (rs_adj == ADJ_ZERO) && r_pol[POL_ONDEC];
        extra    = r_pol[POL_WRAP] && (rs_adj == ADJ_ONE);
        if (rs_req) begin
            if (n_cnt == CZERO && !r_pol[POL_NOTRIG] && !suppress) begin
                fire = 1'b1;
            end
            if (n_cnt == CZERO && !r_pol[POL_NORELOAD]) begin
                n_cnt = n_reload;
            end
            none = (n_cnt == CZERO) && !extra;
            if (none && r_pol[POL_CONT] && n_mode == MODE_PERIODIC && n_reload == CZERO) begin
                none  = 1'b0;
                extra = 1'b1;
            end
            if (none && r_pol[POL_NOTRIG] && rs_adj != ADJ_SKIP) begin
                none  = 1'b0;
                extra = 1'b1;
            end
            if (none && r_pol[POL_NORELOAD] && n_mode == MODE_PERIODIC
                && n_reload != CZERO) begin
                none  = 1'b0;
                extra = 1'b1;
            end
            if (none) begin
                n_mode = MODE_OFF;
            end else begin
                n_ticks = n_cnt;
                n_adjm  = extra;
                n_fresh = 1'b1;
            end
        end

        o_fired = fire;
        o_mode  = n_mode;
        o_shown = read_count(n_mode, n_cnt, n_ticks, n_adjm, n_fresh, n_reload, r_pol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol    <= '0;
            r_ticks  <= '0;
            r_reload <= '0;
            r_cnt    <= '0;
            r_mode   <= MODE_OFF;
            r_adjm   <= 1'b0;
            r_fresh  <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_pol <= i_cfg_wdata;
            end
            if (i_step) begin
                r_ticks  <= n_ticks;
                r_reload <= n_reload;
                r_cnt    <= n_cnt;
                r_mode   <= n_mode;
                r_adjm   <= n_adjm;
                r_fresh  <= n_fresh;
            end
        end
    end

endmodule

### src/policy_countdown_timer_unit.sv
// Top level of the policy countdown timer: input register, timer core, result register.
// A beat passes through the input register, then the core, into the result register.
// Throughput: one beat per cycle; the state update is one pass of logic in pct_core.
// While a finished result waits, the input register takes one more beat, then stalls.
// Reset (i_rst_n low, synchronous) empties both registers, clears the policy bits,
// disables the timer and zeroes count, limit and remaining ticks.
module policy_countdown_timer_unit import pct_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Policy register write.
    input  logic                i_cfg_we,
    input  logic [POLICY_W-1:0] i_cfg_wdata,
    // Command beats.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_kind,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic                i_flag,
    // Result beats.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [SHOWN_W-1:0]  o_count_shown,
    output logic                o_fired,
    output logic [1:0]          o_run_mode
);

    // Input stage. Payload registers carry no reset.
    logic                   r_s1_valid;
    logic [2:0]             r_s1_kind;
    logic [COUNT_WIDTH-1:0] r_s1_value;
    logic                   r_s1_flag;
    logic [COUNT_WIDTH-1:0] in_value;

    // Result stage.
    logic                   r_out_valid;
    logic [SHOWN_W-1:0]     r_count_shown;
    logic                   r_fired;
    logic [1:0]             r_run_mode;

    logic                   out_adv;
    logic                   step;
    logic [COUNT_WIDTH-1:0] core_shown;
    logic                   core_fired;
    t_mode                  core_mode;
    logic [SHOWN_W-1:0]     shown_sat;

    // The value field is cut to, or zero-extended to, the counter width.
    // The readout saturates at the all-ones 32-bit value when the counter is wider.
    generate
        if (COUNT_WIDTH >= VALUE_W) begin : g_wide
            assign in_value  = COUNT_WIDTH'(i_value);
        end else begin : g_narrow
            assign in_value  = i_value[COUNT_WIDTH-1:0];
        end
        if (COUNT_WIDTH > SHOWN_W) begin : g_sat
            assign shown_sat = (|core_shown[COUNT_WIDTH-1:SHOWN_W]) ? '1
                                                                     : core_shown[SHOWN_W-1:0];
        end else begin : g_ext
            assign shown_sat = SHOWN_W'(core_shown);
        end
    endgenerate

    // The result register advances whenever it is empty or being drained; the
    // buffered command executes exactly when it moves into the result register.
    assign out_adv    = !r_out_valid || i_out_ready;
    assign step       = r_s1_valid && out_adv;
    assign o_in_ready = !r_s1_valid || out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_kind  <= i_kind;
            r_s1_value <= in_value;
            r_s1_flag  <= i_flag;
        end
        if (step) begin
            r_count_shown <= shown_sat;
            r_fired       <= core_fired;
            r_run_mode    <= core_mode;
        end
    end

    pct_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_kind      (r_s1_kind),
        .i_value     (r_s1_value),
        .i_flag      (r_s1_flag),
        .o_shown     (core_shown),
        .o_fired     (core_fired),
        .o_mode      (core_mode)
    );

    assign o_out_valid   = r_out_valid;
    assign o_count_shown = r_count_shown;
    assign o_fired       = r_fired;
    assign o_run_mode    = r_run_mode;

endmodule
